FILE: rtl/ctl_pkg.sv
// ----------------------------------------------------------------------------
// ctl_pkg: shared types and constants of the C token lexer
// Mode codes, token kinds, character classes and the keyword table.
// ----------------------------------------------------------------------------
package ctl_pkg;

  localparam int unsigned MaxKeywordChars = 16;
  localparam int unsigned WordIdxW = $clog2(MaxKeywordChars);
  localparam int unsigned NumKw = 42;
  localparam int unsigned KwChars = 14;

  typedef enum logic [6:0] {
    M_IDLE       = 7'b0000001,
    M_WORD       = 7'b0000010,
    M_SPACE      = 7'b0000100,
    M_PEND       = 7'b0001000,
    M_BLOCK      = 7'b0010000,
    M_BLOCK_STAR = 7'b0100000,
    M_LINE       = 7'b1000000
  } mode_e;

  localparam logic [6:0] KIdent   = 7'd69;
  localparam logic [6:0] KSpace   = 7'd70;
  localparam logic [6:0] KComment = 7'd71;
  localparam logic [6:0] KInvalid = 7'd72;
  localparam logic [6:0] KIncr    = 7'd51;
  localparam logic [6:0] KArrow   = 7'd53;
  localparam logic [6:0] KDecr    = 7'd54;
  localparam logic [6:0] KEqEq    = 7'd56;
  localparam logic [6:0] KAndAnd  = 7'd61;

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] len;
  } token_t;

  // Two possible results from one byte.
  typedef struct packed {
    logic   v0;
    token_t t0;
    logic   v1;
    token_t t1;
  } step_out_t;

  typedef logic [KwChars*8-1:0] kw_str_t;

  function automatic kw_str_t kw_text(input logic [5:0] k);
    kw_str_t s;
    string   t;
    s = '0;
    case (k)
      6'd0: t = "auto";       6'd1: t = "break";     6'd2: t = "case";
      6'd3: t = "char";       6'd4: t = "const";     6'd5: t = "continue";
      6'd6: t = "default";    6'd7: t = "do";        6'd8: t = "double";
      6'd9: t = "else";       6'd10: t = "enum";     6'd11: t = "extern";
      6'd12: t = "float";     6'd13: t = "for";      6'd14: t = "goto";
      6'd15: t = "if";        6'd16: t = "inline";   6'd17: t = "int";
      6'd18: t = "long";      6'd19: t = "register"; 6'd20: t = "restrict";
      6'd21: t = "return";    6'd22: t = "short";    6'd23: t = "signed";
      6'd24: t = "sizeof";    6'd25: t = "static";   6'd26: t = "struct";
      6'd27: t = "switch";    6'd28: t = "typedef";  6'd29: t = "union";
      6'd30: t = "unsigned";  6'd31: t = "void";     6'd32: t = "volatile";
      6'd33: t = "while";     6'd34: t = "_Alignas"; 6'd35: t = "_Alignof";
      6'd36: t = "_Atomic";   6'd37: t = "_Bool";    6'd38: t = "_Generic";
      6'd39: t = "_Noreturn"; 6'd40: t = string'({"_Static", "_assert"});
      default: t = string'({"_Thread", "_local"});
    endcase
    // character i in bits [8*i +: 8]
    for (int i = 0; i < t.len(); i++) begin
      s[8*i +: 8] = t[i];
    end
    return s;
  endfunction

  function automatic logic [4:0] kw_len(input logic [5:0] k);
    kw_str_t s;
    logic [4:0] n;
    s = kw_text(k);
    n = '0;
    for (int i = 0; i < KwChars; i++) begin
      if (s[8*i +: 8] != 8'd0) n = 5'(i + 1);
    end
    return n;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_ext(input logic [7:0] c);
    return c == "+" || c == "-" || c == "=" || c == "&" || c == "/";
  endfunction

  function automatic logic [6:0] single_kind(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      "(": k = 7'd42; ")": k = 7'd43; "[": k = 7'd44; "]": k = 7'd45;
      "{": k = 7'd46; "}": k = 7'd47; "<": k = 7'd48; ">": k = 7'd49;
      "#": k = 7'd50; "+": k = 7'd52; "-": k = 7'd55; "=": k = 7'd57;
      "*": k = 7'd58; "/": k = 7'd59; "%": k = 7'd60; "&": k = 7'd62;
      "|": k = 7'd63; "^": k = 7'd64; "~": k = 7'd65; "!": k = 7'd66;
      ".": k = 7'd67; ";": k = 7'd68;
      default: k = KInvalid;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/ctl_kw_match.sv
// ----------------------------------------------------------------------------
// ctl_kw_match: keyword classifier
// Compares the open word against all keywords in parallel.
// ----------------------------------------------------------------------------
module ctl_kw_match import ctl_pkg::*; (
  input  logic [MaxKeywordChars*8-1:0] word_i,
  input  logic [15:0]                  len_i,
  output logic [6:0]                   kind_o
);

  logic [NumKw-1:0] hit;

  always_comb begin
    for (int k = 0; k < NumKw; k++) begin
      kw_str_t t;
      logic    eq;
      t  = kw_text(6'(k));
      eq = (len_i == 16'(kw_len(6'(k))));
      for (int i = 0; i < KwChars; i++) begin
        if (i < 32'(kw_len(6'(k))) && word_i[8*i +: 8] != t[8*i +: 8]) eq = 1'b0;
      end
      hit[k] = eq;
    end
  end

  always_comb begin
    kind_o = KIdent;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (hit[k]) kind_o = 7'(k);
    end
  end

endmodule

FILE: rtl/ctl_step.sv
// ----------------------------------------------------------------------------
// ctl_step: lexer state step
// Next state and closed tokens for one accepted byte.
// ----------------------------------------------------------------------------
module ctl_step import ctl_pkg::*; (
  input  mode_e       mode_i,
  input  logic [15:0] len_i,
  input  logic [7:0]  pend_i,
  input  logic [6:0]  word_kind_i,
  input  logic [7:0]  c_i,
  output mode_e       mode_o,
  output logic [15:0] len_o,
  output logic        wr_word_o,
  output logic        pend_we_o,
  output step_out_t   res_o
);

  logic [15:0] grown;
  assign grown = (len_i == 16'hFFFF) ? len_i : len_i + 16'd1;

  always_comb begin
    token_t fl;
    logic   restart;
    fl.kind   = KComment;
    fl.len    = len_i;
    restart   = 1'b0;
    mode_o    = mode_i;
    len_o     = len_i;
    wr_word_o = 1'b0;
    pend_we_o = 1'b0;
    res_o     = '0;
    case (mode_i)
      M_WORD: begin
        fl.kind = word_kind_i;
        if (is_word(c_i)) begin
          wr_word_o = 1'b1; len_o = grown;
        end else restart = 1'b1;
      end
      M_SPACE: begin
        fl.kind = KSpace;
        if (is_space(c_i)) len_o = grown;
        else restart = 1'b1;
      end
      M_PEND: begin
        fl.kind = single_kind(pend_i);
        fl.len  = 16'd1;
        mode_o  = M_IDLE;
        len_o   = 16'd0;
        res_o.t0.len = 16'd2;
        res_o.v0 = 1'b1;
        if (pend_i == "+" && c_i == "+") res_o.t0.kind = KIncr;
        else if (pend_i == "-" && c_i == ">") res_o.t0.kind = KArrow;
        else if (pend_i == "-" && c_i == "-") res_o.t0.kind = KDecr;
        else if (pend_i == "=" && c_i == "=") res_o.t0.kind = KEqEq;
        else if (pend_i == "&" && c_i == "&") res_o.t0.kind = KAndAnd;
        else if (pend_i == "/" && c_i == "*") begin
          res_o.v0 = 1'b0; mode_o = M_BLOCK; len_o = 16'd2;
        end else if (pend_i == "/" && c_i == "/") begin
          res_o.v0 = 1'b0; mode_o = M_LINE; len_o = 16'd2;
        end else begin
          res_o.v0 = 1'b0; restart = 1'b1;
        end
      end
      M_BLOCK: begin
        len_o = grown;
        if (c_i == "*") mode_o = M_BLOCK_STAR;
      end
      M_BLOCK_STAR: begin
        len_o = grown;
        if (c_i == "/") begin
          res_o.v0 = 1'b1; res_o.t0.kind = KComment; res_o.t0.len = grown;
          mode_o = M_IDLE; len_o = 16'd0;
        end else if (c_i != "*") mode_o = M_BLOCK;
      end
      M_LINE: begin
        len_o = grown;
        if (c_i == 8'h0A) begin
          res_o.v0 = 1'b1; res_o.t0.kind = KComment; res_o.t0.len = grown;
          mode_o = M_IDLE; len_o = 16'd0;
        end
      end
      default: restart = 1'b1;
    endcase

    if (restart) begin
      // close the open token, then start on this byte
      if (mode_i != M_IDLE) begin
        res_o.v0 = 1'b1; res_o.t0 = fl;
      end
      len_o = 16'd1;
      if (is_alpha(c_i)) begin
        mode_o = M_WORD; wr_word_o = 1'b1;
      end else if (is_space(c_i)) mode_o = M_SPACE;
      else if (is_ext(c_i)) begin
        mode_o = M_PEND; pend_we_o = 1'b1;
      end else begin
        mode_o = M_IDLE; len_o = 16'd0;
        res_o.v1 = 1'b1; res_o.t1.kind = single_kind(c_i); res_o.t1.len = 16'd1;
      end
    end
    // pack a lone second token into the first slot
    if (!res_o.v0 && res_o.v1) begin
      res_o.v0 = 1'b1; res_o.t0 = res_o.t1; res_o.v1 = 1'b0;
    end
  end

endmodule

FILE: rtl/c_token_lexer.sv
// ----------------------------------------------------------------------------
// c_token_lexer: streaming C lexer, one source byte per cycle while results drain
// Classifies keywords, punctuators, identifiers, whitespace and comments.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one source byte per request; tdata = char_code, tuser =
//   end_of_text (set on the final byte, flushes the open token).
//   m_axis: one token per request; tdata = {length, kind}, tlast marks the
//   last token caused by one input byte.
//   Each byte passes the input register and the classify and state-update
//   logic into a two-entry result register. Its first token is valid once
//   the byte has passed both registers; throughput is one byte per cycle
//   while the result slots drain, limited by the single lexer state
//   register. A byte that closes two tokens (a word then a punctuator)
//   holds the input side while the second token drains.
//   Reset returns the lexer to idle with no open token. When the receiver
//   stalls, results hold in place and tready drops once a result waits and
//   the input register is full; nothing is lost.
// ----------------------------------------------------------------------------
module c_token_lexer import ctl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [6:0] token_kind, [22:7] token_length
  output logic        m_axis_tlast
);

  // input register
  logic       in_v_q;
  logic [7:0] in_c_q;
  logic       in_eot_q;

  // lexer state
  mode_e       mode_q;
  logic [15:0] len_q;
  logic [7:0]  pend_q;
  logic [7:0]  word_q [MaxKeywordChars];
  logic [MaxKeywordChars*8-1:0] word_flat;

  // result slots: slot 0 presents, slot 1 waits
  logic   r0_v_q, r1_v_q, r0_last_q, r1_last_q;
  token_t r0_q, r1_q;

  logic [6:0]  word_kind;
  mode_e       m1;
  logic [15:0] l1;
  logic        wr_word, pend_we;
  step_out_t   sr;
  step_out_t   res;
  mode_e       mode_d;
  logic [15:0] len_d;
  logic        out_pop, slots_free, proc;

  always_comb begin
    for (int i = 0; i < MaxKeywordChars; i++) word_flat[8*i +: 8] = word_q[i];
  end

  ctl_kw_match u_kw (.word_i(word_flat), .len_i(len_q), .kind_o(word_kind));

  ctl_step u_step (
    .mode_i(mode_q), .len_i(len_q), .pend_i(pend_q), .word_kind_i(word_kind),
    .c_i(in_c_q), .mode_o(m1), .len_o(l1),
    .wr_word_o(wr_word), .pend_we_o(pend_we), .res_o(sr)
  );

  // End of text: flush whatever is still open after this byte.
  always_comb begin
    token_t ft;
    res    = sr;
    mode_d = m1;
    len_d  = l1;
    ft.len = l1;
    case (m1)
      M_WORD:  ft.kind = eot_word_kind(l1);
      M_SPACE: ft.kind = KSpace;
      M_PEND:  begin
        ft.kind = single_kind(pend_we ? in_c_q : pend_q); ft.len = 16'd1;
      end
      default: ft.kind = KComment;
    endcase
    if (in_eot_q && m1 != M_IDLE) begin
      mode_d = M_IDLE;
      len_d  = 16'd0;
      if (res.v0) begin
        res.v1 = 1'b1; res.t1 = ft;
      end else begin
        res.v0 = 1'b1; res.t0 = ft;
      end
    end
  end

  // keyword check of the word as it stands after this byte
  logic [MaxKeywordChars*8-1:0] word_next;
  logic [6:0] word_kind_next;
  always_comb begin
    word_next = word_flat;
    if (wr_word && l1 <= 16'(MaxKeywordChars)) begin
      word_next[8*(WordIdxW'(l1 - 16'd1)) +: 8] = in_c_q;
    end
  end
  ctl_kw_match u_kw_eot (.word_i(word_next), .len_i(l1), .kind_o(word_kind_next));

  function automatic logic [6:0] eot_word_kind(input logic [15:0] l);
    return (l > 16'(MaxKeywordChars)) ? KIdent : word_kind_next;
  endfunction

  // results are accepted only when slot 1 is empty and slot 0 is empty or draining
  assign out_pop    = m_axis_tvalid && m_axis_tready;
  assign slots_free = !r1_v_q && (!r0_v_q || out_pop);
  assign proc       = in_v_q && slots_free;
  assign s_axis_tready = !in_v_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      mode_q <= M_IDLE;
      len_q  <= '0;
      pend_q <= '0;
      r0_v_q <= 1'b0;
      r1_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_v_q <= s_axis_tvalid;
      if (proc) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        if (pend_we) pend_q <= in_c_q;
        r0_v_q <= res.v0;
        r1_v_q <= res.v1;
      end else if (out_pop) begin
        r0_v_q <= r1_v_q;
        r1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_c_q   <= s_axis_tdata;
      in_eot_q <= s_axis_tuser;
    end
    if (proc) begin
      r0_q      <= res.t0;
      r1_q      <= res.t1;
      r0_last_q <= !res.v1;
      r1_last_q <= 1'b1;
      if (wr_word && l1 <= 16'(MaxKeywordChars)) begin
        word_q[WordIdxW'(l1 - 16'd1)] <= in_c_q;
      end
    end else if (out_pop) begin
      r0_q      <= r1_q;
      r0_last_q <= r1_last_q;
    end
  end

  assign m_axis_tvalid = r0_v_q;
  assign m_axis_tdata  = {1'b0, r0_q.len, r0_q.kind};
  assign m_axis_tlast  = r0_last_q;

  // second slot only fills behind a first one
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r1_v_q |-> r0_v_q) else $error("second result without first");

  // no new byte is processed while a second token is waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r1_v_q |-> !proc) else $error("result overrun");

  // end of text always leaves the lexer idle
  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_eot_q) |=> (mode_q == M_IDLE)) else $error("open token after end");

endmodule
